FILE: rtl/core/skft_pkg.sv
// ----------------------------------------------------------------------------
// skft_pkg: shared types and constants of the source keyed forwarding table
// Action and status codes, back end command codes, the result word layout and
// width helpers used by every module of the block.
// ----------------------------------------------------------------------------
package skft_pkg;

  localparam int RULE_ENTRIES_DEF  = 16;
  localparam int DSTS_PER_RULE_DEF = 4;
  localparam int KEY_W             = 32;
  localparam int DST_W             = 32;
  localparam int CMD_FIFO_DEPTH    = 2;
  localparam int RES_FIFO_DEPTH    = 4;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_DIR  = 3'd1,
    ST_DUP  = 3'd2,
    ST_FULL = 3'd3,
    ST_NONE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_STATUS = 3'd0,
    CMD_NEW    = 3'd1,
    CMD_INS    = 3'd2,
    CMD_REM    = 3'd3,
    CMD_LOOK   = 3'd4
  } cmd_op_t;

  typedef struct packed {
    status_t            status;
    logic               dir;
    logic [DST_W-1:0]   dst;
    logic               last;
  } res_t;

  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int cnt_bits(input int n);
    return $clog2(n + 1);
  endfunction

  // op + status + rule index + count + direction + value
  function automatic int cmd_bits(input int rules, input int dsts);
    return 3 + 3 + idx_bits(rules) + cnt_bits(dsts) + 1 + DST_W;
  endfunction

  // valid + rule index + new count
  function automatic int upd_bits(input int rules, input int dsts);
    return 1 + idx_bits(rules) + cnt_bits(dsts);
  endfunction

endpackage

FILE: rtl/core/skft_ram.sv
// ----------------------------------------------------------------------------
// skft_ram: generic single write, single read RAM
// One write port and one read port per cycle; read data is registered and
// holds its value while no read is issued.
// ----------------------------------------------------------------------------
module skft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [skft_pkg::idx_bits(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [skft_pkg::idx_bits(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/skft_fifo.sv
// ----------------------------------------------------------------------------
// skft_fifo: small flop based first-in first-out queue
// Used between the front and back end and in front of the result port.
// ----------------------------------------------------------------------------
module skft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = skft_pkg::idx_bits(DEPTH);
  localparam int CW = skft_pkg::cnt_bits(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/skft_front.sv
// ----------------------------------------------------------------------------
// skft_front: request capture, rule match and classification
// Holds the rule table (key, direction, destination count), matches the source
// address against all rules, and turns each request into one back end command.
// ----------------------------------------------------------------------------
module skft_front #(
  parameter int RULE_ENTRIES  = skft_pkg::RULE_ENTRIES_DEF,
  parameter int DSTS_PER_RULE = skft_pkg::DSTS_PER_RULE_DEF
) (
  input  logic                                                       clk,
  input  logic                                                       rst_n,
  input  logic                                                       in_push,
  input  logic [1:0]                                                 in_action,
  input  logic [skft_pkg::KEY_W-1:0]                                 in_src_ip,
  input  logic                                                       in_direction,
  input  logic [skft_pkg::DST_W-1:0]                                 in_dst_value,
  output logic                                                       in_full,
  output logic                                                       cmd_push,
  output logic [skft_pkg::cmd_bits(RULE_ENTRIES, DSTS_PER_RULE)-1:0] cmd_data,
  input  logic                                                       cmdq_empty,
  input  logic                                                       back_busy,
  input  logic [skft_pkg::upd_bits(RULE_ENTRIES, DSTS_PER_RULE)-1:0] upd_data
);

  localparam int RIDX_W = skft_pkg::idx_bits(RULE_ENTRIES);
  localparam int CNT_W  = skft_pkg::cnt_bits(DSTS_PER_RULE);

  typedef struct packed {
    logic [1:0]                 action;
    logic [skft_pkg::KEY_W-1:0] src;
    logic                       dir;
    logic [skft_pkg::DST_W-1:0] val;
  } item_t;

  typedef struct packed {
    skft_pkg::cmd_op_t          op;
    skft_pkg::status_t          status;
    logic [RIDX_W-1:0]          ridx;
    logic [CNT_W-1:0]           cnt;
    logic                       dir;
    logic [skft_pkg::DST_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic              v;
    logic [RIDX_W-1:0] ridx;
    logic [CNT_W-1:0]  cnt;
  } upd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WAIT,
    F_CLASS
  } fstate_t;

  fstate_t                    state_r;
  fstate_t                    state_nxt;
  item_t                      item_r;
  logic [RULE_ENTRIES-1:0]    match_r;
  logic [RULE_ENTRIES-1:0]    free_r;
  logic [skft_pkg::KEY_W-1:0] key_r   [RULE_ENTRIES];
  logic                       dir_r   [RULE_ENTRIES];
  logic [CNT_W-1:0]           count_r [RULE_ENTRIES];

  logic [RULE_ENTRIES-1:0]    used;
  logic [RULE_ENTRIES-1:0]    match_nxt;
  logic [RULE_ENTRIES-1:0]    free_nxt;
  logic                       quiet;
  logic                       found;
  logic                       have_free;
  logic [RIDX_W-1:0]          hit_idx;
  logic [RIDX_W-1:0]          free_idx;
  logic [CNT_W-1:0]           hit_cnt;
  logic                       hit_dir;
  logic                       new_rule;
  cmd_t                       cmd;
  upd_t                       upd;

  // At most one bit is set, so OR-ing the indexes of set bits encodes it.
  function automatic logic [RIDX_W-1:0] enc(input logic [RULE_ENTRIES-1:0] v);
    logic [RIDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < RULE_ENTRIES; i++) begin
      if (v[i]) begin
        idx = idx | RIDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign upd   = upd_t'(upd_data);
  assign quiet = cmdq_empty && !back_busy;

  always_comb begin
    for (int i = 0; i < RULE_ENTRIES; i++) begin
      used[i]      = (count_r[i] != '0);
      match_nxt[i] = used[i] && (key_r[i] == item_r.src);
    end
    // Lowest clear bit of the used vector.
    free_nxt = ~used & (used + RULE_ENTRIES'(1));
  end

  assign found     = |match_r;
  assign have_free = |free_r;
  assign hit_idx   = enc(match_r);
  assign free_idx  = enc(free_r);
  assign hit_cnt   = count_r[hit_idx];
  assign hit_dir   = dir_r[hit_idx];

  always_comb begin
    cmd        = '0;
    cmd.op     = skft_pkg::CMD_STATUS;
    cmd.status = skft_pkg::ST_NONE;
    cmd.ridx   = hit_idx;
    cmd.cnt    = hit_cnt;
    cmd.dir    = item_r.dir;
    cmd.val    = item_r.val;
    new_rule   = 1'b0;
    case (skft_pkg::action_t'(item_r.action))
      skft_pkg::ACT_INSERT: begin
        if (found) begin
          if (hit_dir != item_r.dir) begin
            cmd.status = skft_pkg::ST_DIR;
          end else begin
            cmd.op = skft_pkg::CMD_INS;
          end
        end else if (have_free) begin
          cmd.op   = skft_pkg::CMD_NEW;
          cmd.ridx = free_idx;
          new_rule = (state_r == F_CLASS);
        end else begin
          cmd.status = skft_pkg::ST_FULL;
        end
      end
      skft_pkg::ACT_REMOVE: begin
        if (found) begin
          if (hit_dir != item_r.dir) begin
            cmd.status = skft_pkg::ST_DIR;
          end else begin
            cmd.op = skft_pkg::CMD_REM;
          end
        end
      end
      skft_pkg::ACT_LOOKUP: begin
        if (found) begin
          cmd.op  = skft_pkg::CMD_LOOK;
          cmd.dir = hit_dir;
        end
      end
      default: begin
        cmd.status = skft_pkg::ST_NONE;
      end
    endcase
  end

  assign cmd_push = (state_r == F_CLASS);
  assign cmd_data = cmd;
  assign in_full  = (state_r != F_IDLE) || !rst_n;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          state_nxt = F_WAIT;
        end
      end
      // The table is read only once the back end has finished every update.
      F_WAIT: begin
        if (quiet) begin
          state_nxt = F_CLASS;
        end
      end
      F_CLASS: begin
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      for (int i = 0; i < RULE_ENTRIES; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (upd.v) begin
        count_r[upd.ridx] <= upd.cnt;
      end
      if (new_rule) begin
        count_r[free_idx] <= CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_push) begin
      item_r.action <= in_action;
      item_r.src    <= in_src_ip;
      item_r.dir    <= in_direction;
      item_r.val    <= in_dst_value;
    end
    if (state_r == F_WAIT) begin
      match_r <= match_nxt;
      free_r  <= free_nxt;
    end
    if (new_rule) begin
      key_r[free_idx] <= item_r.src;
      dir_r[free_idx] <= item_r.dir;
    end
  end

endmodule

FILE: rtl/core/skft_back.sv
// ----------------------------------------------------------------------------
// skft_back: destination list engine
// Owns the destination memory. Scans a rule's list for duplicates or the entry
// to remove, appends, closes gaps on removal, streams lookups and writes the
// result words.
// ----------------------------------------------------------------------------
module skft_back #(
  parameter int RULE_ENTRIES  = skft_pkg::RULE_ENTRIES_DEF,
  parameter int DSTS_PER_RULE = skft_pkg::DSTS_PER_RULE_DEF
) (
  input  logic                                                       clk,
  input  logic                                                       rst_n,
  input  logic [skft_pkg::cmd_bits(RULE_ENTRIES, DSTS_PER_RULE)-1:0] cmd_data,
  input  logic                                                       cmdq_empty,
  output logic                                                       cmd_pop,
  output logic                                                       busy,
  output logic [skft_pkg::upd_bits(RULE_ENTRIES, DSTS_PER_RULE)-1:0] upd_data,
  output logic                                                       res_push,
  output skft_pkg::res_t                                             res_data,
  input  logic                                                       res_full
);

  localparam int RIDX_W = skft_pkg::idx_bits(RULE_ENTRIES);
  localparam int CNT_W  = skft_pkg::cnt_bits(DSTS_PER_RULE);
  localparam int SLOT_W = skft_pkg::idx_bits(DSTS_PER_RULE);
  localparam int DEPTH  = RULE_ENTRIES * DSTS_PER_RULE;
  localparam int ADDR_W = skft_pkg::idx_bits(DEPTH);

  typedef struct packed {
    skft_pkg::cmd_op_t          op;
    skft_pkg::status_t          status;
    logic [RIDX_W-1:0]          ridx;
    logic [CNT_W-1:0]           cnt;
    logic                       dir;
    logic [skft_pkg::DST_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic              v;
    logic [RIDX_W-1:0] ridx;
    logic [CNT_W-1:0]  cnt;
  } upd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_SHIFT,
    B_LOOK,
    B_EMIT
  } bstate_t;

  bstate_t                    state_r;
  bstate_t                    state_nxt;
  cmd_t                       cmd_r;
  cmd_t                       cmd_in;
  logic [CNT_W-1:0]           idx_r;
  logic [CNT_W-1:0]           idx_nxt;
  logic [SLOT_W-1:0]          pos_r;
  logic [SLOT_W-1:0]          pos_nxt;
  logic                       have_r;
  logic                       have_nxt;
  skft_pkg::status_t          status_r;
  skft_pkg::status_t          status_nxt;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [skft_pkg::DST_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [skft_pkg::DST_W-1:0] mem_rdata;
  logic                       hit;
  logic                       last_pos;
  logic                       push_ok;
  upd_t                       upd;

  function automatic logic [ADDR_W-1:0] addr(input logic [RIDX_W-1:0] ridx,
                                             input logic [CNT_W-1:0]  slot);
    return ADDR_W'(int'(ridx) * DSTS_PER_RULE + int'(slot));
  endfunction

  skft_ram #(
    .WIDTH (skft_pkg::DST_W),
    .DEPTH (DEPTH)
  ) u_dst_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cmd_in   = cmd_t'(cmd_data);
  assign busy     = (state_r != B_IDLE);
  assign upd_data = upd;
  assign hit      = have_r && (mem_rdata == cmd_r.val);
  assign last_pos = (CNT_W'(pos_r) == cmd_r.cnt - 1'b1);
  assign push_ok  = have_r && !res_full;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    have_nxt        = have_r;
    status_nxt      = status_r;
    cmd_pop         = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = addr(cmd_r.ridx, cmd_r.cnt);
    mem_wdata       = cmd_r.val;
    mem_re          = 1'b0;
    mem_raddr       = addr(cmd_r.ridx, idx_r);
    upd             = '0;
    res_push        = 1'b0;
    res_data        = '0;
    res_data.status = status_r;
    res_data.last   = 1'b1;
    case (state_r)
      B_IDLE: begin
        if (!cmdq_empty) begin
          cmd_pop  = 1'b1;
          idx_nxt  = '0;
          have_nxt = 1'b0;
          case (cmd_in.op)
            skft_pkg::CMD_NEW: begin
              mem_we     = 1'b1;
              mem_waddr  = addr(cmd_in.ridx, '0);
              mem_wdata  = cmd_in.val;
              status_nxt = skft_pkg::ST_OK;
              state_nxt  = B_EMIT;
            end
            skft_pkg::CMD_INS,
            skft_pkg::CMD_REM: begin
              state_nxt = B_SCAN;
            end
            skft_pkg::CMD_LOOK: begin
              state_nxt = B_LOOK;
            end
            default: begin
              status_nxt = cmd_in.status;
              state_nxt  = B_EMIT;
            end
          endcase
        end
      end
      // One read per cycle; each entry is compared the cycle after its read.
      B_SCAN: begin
        if (hit) begin
          if (cmd_r.op == skft_pkg::CMD_INS) begin
            status_nxt = skft_pkg::ST_DUP;
            state_nxt  = B_EMIT;
          end else begin
            idx_nxt   = CNT_W'(pos_r) + 1'b1;
            have_nxt  = 1'b0;
            state_nxt = B_SHIFT;
          end
        end else if (have_r && last_pos) begin
          state_nxt = B_EMIT;
          if (cmd_r.op == skft_pkg::CMD_REM) begin
            status_nxt = skft_pkg::ST_NONE;
          end else if (cmd_r.cnt == CNT_W'(DSTS_PER_RULE)) begin
            status_nxt = skft_pkg::ST_FULL;
          end else begin
            mem_we     = 1'b1;
            upd.v      = 1'b1;
            upd.ridx   = cmd_r.ridx;
            upd.cnt    = cmd_r.cnt + 1'b1;
            status_nxt = skft_pkg::ST_OK;
          end
        end else if (idx_r < cmd_r.cnt) begin
          mem_re   = 1'b1;
          pos_nxt  = SLOT_W'(idx_r);
          idx_nxt  = idx_r + 1'b1;
          have_nxt = 1'b1;
        end else begin
          have_nxt = 1'b0;
        end
      end
      // Each entry behind the removed one moves down by one slot.
      B_SHIFT: begin
        if (have_r) begin
          mem_we    = 1'b1;
          mem_waddr = addr(cmd_r.ridx, CNT_W'(pos_r) - 1'b1);
          mem_wdata = mem_rdata;
        end
        if (idx_r < cmd_r.cnt) begin
          mem_re   = 1'b1;
          pos_nxt  = SLOT_W'(idx_r);
          idx_nxt  = idx_r + 1'b1;
          have_nxt = 1'b1;
        end else begin
          have_nxt = 1'b0;
          if (!have_r) begin
            upd.v      = 1'b1;
            upd.ridx   = cmd_r.ridx;
            upd.cnt    = cmd_r.cnt - 1'b1;
            status_nxt = skft_pkg::ST_OK;
            state_nxt  = B_EMIT;
          end
        end
      end
      // A new read is issued only when no word is held or the held word leaves this cycle.
      B_LOOK: begin
        if (push_ok) begin
          res_push        = 1'b1;
          res_data.status = skft_pkg::ST_OK;
          res_data.dir    = cmd_r.dir;
          res_data.dst    = mem_rdata;
          res_data.last   = last_pos;
        end
        if (push_ok && last_pos) begin
          have_nxt  = 1'b0;
          state_nxt = B_IDLE;
        end else if ((idx_r < cmd_r.cnt) && (!have_r || push_ok)) begin
          mem_re   = 1'b1;
          pos_nxt  = SLOT_W'(idx_r);
          idx_nxt  = idx_r + 1'b1;
          have_nxt = 1'b1;
        end else if (push_ok) begin
          have_nxt = 1'b0;
        end
      end
      B_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      have_r   <= 1'b0;
      idx_r    <= '0;
      pos_r    <= '0;
      status_r <= skft_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      have_r   <= have_nxt;
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/source_keyed_forwarding_table.sv
// ----------------------------------------------------------------------------
// source_keyed_forwarding_table: exact match forwarding table keyed by source
// Requests enter through a queue style port (in_push / in_full) and result
// words leave through another (out_empty / out_pop). The oldest result word
// sits on the out_ ports while out_empty is low.
// Insert and remove give one result word; a lookup that finds its rule gives
// one word per destination in list order, out_last marks the final word.
// The front end takes one request at a time: it waits until the back end has
// finished the previous command, then matches the source against all rules
// and classifies it. The back end works through the rule's list in a memory
// with one read and one write port, one entry per cycle; a lookup moves on
// only while the result queue has room.
// Results go through a small output queue; while it is full the back end
// holds, and in_full stays high once a request is waiting behind it.
// Synchronous reset empties all rules and queues and holds in_full high; the
// destination memory needs no clearing.
// ----------------------------------------------------------------------------
module source_keyed_forwarding_table #(
  parameter int RULE_ENTRIES  = skft_pkg::RULE_ENTRIES_DEF,
  parameter int DSTS_PER_RULE = skft_pkg::DSTS_PER_RULE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_action,
  input  logic [skft_pkg::KEY_W-1:0] in_src_ip,
  input  logic                       in_direction,
  input  logic [skft_pkg::DST_W-1:0] in_dst_value,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [2:0]                 out_status,
  output logic                       out_rule_direction,
  output logic [skft_pkg::DST_W-1:0] out_dst_out,
  output logic                       out_last
);

  localparam int CMD_W = skft_pkg::cmd_bits(RULE_ENTRIES, DSTS_PER_RULE);
  localparam int UPD_W = skft_pkg::upd_bits(RULE_ENTRIES, DSTS_PER_RULE);
  localparam int RES_W = $bits(skft_pkg::res_t);

  logic             cmd_push;
  logic [CMD_W-1:0] cmd_wdata;
  logic [CMD_W-1:0] cmd_rdata;
  logic             cmdq_empty;
  logic             cmd_pop;
  logic             back_busy;
  logic [UPD_W-1:0] upd_data;
  logic             res_push;
  skft_pkg::res_t   res_wdata;
  logic [RES_W-1:0] res_rdata;
  logic             res_full;
  skft_pkg::res_t   res_head;

  skft_front #(
    .RULE_ENTRIES  (RULE_ENTRIES),
    .DSTS_PER_RULE (DSTS_PER_RULE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_action    (in_action),
    .in_src_ip    (in_src_ip),
    .in_direction (in_direction),
    .in_dst_value (in_dst_value),
    .in_full      (in_full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata),
    .cmdq_empty   (cmdq_empty),
    .back_busy    (back_busy),
    .upd_data     (upd_data)
  );

  skft_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (skft_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmdq_empty)
  );

  skft_back #(
    .RULE_ENTRIES  (RULE_ENTRIES),
    .DSTS_PER_RULE (DSTS_PER_RULE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_data   (cmd_rdata),
    .cmdq_empty (cmdq_empty),
    .cmd_pop    (cmd_pop),
    .busy       (back_busy),
    .upd_data   (upd_data),
    .res_push   (res_push),
    .res_data   (res_wdata),
    .res_full   (res_full)
  );

  skft_fifo #(
    .WIDTH (RES_W),
    .DEPTH (skft_pkg::RES_FIFO_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_head           = skft_pkg::res_t'(res_rdata);
  assign out_status         = res_head.status;
  assign out_rule_direction = res_head.dir;
  assign out_dst_out        = res_head.dst;
  assign out_last           = res_head.last;

endmodule
